### rtl/wheel_speed_odometer_macros.svh
// assertion macros shared by the checker
`ifndef WHEEL_SPEED_ODOMETER_MACROS_SVH
`define WHEEL_SPEED_ODOMETER_MACROS_SVH

// condition in one cycle implies a property in the next
`define WSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// condition implies a property in the same cycle
`define WSO_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/wso_pkg.sv
package wso_pkg;

    // operation codes
    localparam logic [1:0] OP_PULSE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_TRIP  = 2'd2;

    // defaults and scaling constants
    localparam int unsigned DEBOUNCE_DEF = 100;
    localparam logic [7:0]  DIAM_RESET   = 8'd24;
    localparam int unsigned SPEED_FACTOR = 287;
    localparam int unsigned ACCEL_FACTOR = 278;
    localparam int unsigned TRIP_NUM     = 1000;
    localparam int unsigned TRIP_DEN     = 12547;

    // reciprocal of the trip divisor, exact for any 32-bit dividend
    localparam int unsigned TRIP_SHIFT = 46;
    localparam logic [32:0] TRIP_RECIP =
        33'(((64'd1 << TRIP_SHIFT) - 64'd1) / 64'(TRIP_DEN) + 64'd1);

    // shared divider geometry
    localparam int unsigned DIVIDEND_W = 50;
    localparam int unsigned DIVISOR_W  = 32;
    localparam int unsigned STEP_W     = 6;
    localparam logic [STEP_W-1:0] STEPS_VEL  = 6'd25;
    localparam logic [STEP_W-1:0] STEPS_ACC  = 6'd34;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [31:0] initial_distance_m;
    } t_in_item;

    typedef struct packed {
        logic [23:0]        speed_kmh_q8;
        logic signed [31:0] accel_q8;
        logic [31:0]        trip_m;
        logic [31:0]        total_m;
    } t_out_item;

    // which quotient the divider is working on
    typedef enum logic [1:0] {
        DIV_V0  = 2'd0,
        DIV_V1  = 2'd1,
        DIV_ACC = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     take;
        logic     prep;
        logic     mul;
        logic     tsplit;
        logic     trem;
        logic     tq2;
        logic     tsum;
        logic     div_start;
        t_div_sel div_sel;
        logic     amul;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       moving;
        logic       mag_zero;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

### rtl/wso_div.sv
module wso_div #(
    parameter int unsigned DIVIDEND_W = wso_pkg::DIVIDEND_W,
    parameter int unsigned DIVISOR_W  = wso_pkg::DIVISOR_W,
    parameter int unsigned STEP_W     = wso_pkg::STEP_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    input  logic [STEP_W-1:0]     i_steps,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    import wso_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
    end

    // control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: dividend bits shift out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/wso_ctrl.sv
module wso_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output wso_pkg::t_cmd o_cmd,
    input  wso_pkg::t_sts i_sts
);
    import wso_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0_0000_0000_0001,
        S_PREP = 13'b0_0000_0000_0010,
        S_MUL  = 13'b0_0000_0000_0100,
        S_TSPL = 13'b0_0000_0000_1000,
        S_TREM = 13'b0_0000_0001_0000,
        S_TQ2  = 13'b0_0000_0010_0000,
        S_TSUM = 13'b0_0000_0100_0000,
        S_VEL0 = 13'b0_0000_1000_0000,
        S_VEL1 = 13'b0_0001_0000_0000,
        S_AMUL = 13'b0_0010_0000_0000,
        S_AGO  = 13'b0_0100_0000_0000,
        S_ACC  = 13'b0_1000_0000_0000,
        S_OUT  = 13'b1_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // next state and commands to the datapath
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.take = 1'b1;
                    if (i_sts.op == OP_QUERY) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_TSPL;
            end
            S_TSPL: begin
                cmd.tsplit = 1'b1;
                n_state    = S_TREM;
            end
            S_TREM: begin
                cmd.trem = 1'b1;
                n_state  = S_TQ2;
            end
            S_TQ2: begin
                cmd.tq2 = 1'b1;
                n_state = S_TSUM;
            end
            S_TSUM: begin
                cmd.tsum = 1'b1;
                if (i_sts.moving) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_V0;
                    n_state       = S_VEL0;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_VEL0: begin
                if (i_sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_V1;
                    n_state       = S_VEL1;
                end
            end
            S_VEL1: begin
                if (i_sts.div_done) begin
                    n_state = S_AMUL;
                end
            end
            S_AMUL: begin
                cmd.amul = 1'b1;
                n_state  = S_AGO;
            end
            S_AGO: begin
                if (i_sts.mag_zero) begin
                    n_state = S_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_ACC;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

### rtl/wso_dpath.sv
module wso_dpath #(
    parameter int unsigned DEBOUNCE_MS = wso_pkg::DEBOUNCE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  wso_pkg::t_in_item  i_in_data,
    input  wso_pkg::t_cmd      i_cmd,
    output wso_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wso_pkg::t_out_item o_out_data
);
    import wso_pkg::*;

    localparam logic [31:0] DEBOUNCE_W = 32'(DEBOUNCE_MS);

    // configuration and pulse history
    logic [7:0]  r_diam;
    logic [31:0] r_newest;
    logic [31:0] r_prev;
    logic [31:0] r_older;
    logic [31:0] r_count;
    logic [31:0] r_init;

    // query working registers
    logic [31:0] r_now;
    logic [31:0] r_d0;
    logic [31:0] r_d1;
    logic [16:0] r_k;
    logic [17:0] r_dk;
    logic [18:0] r_q1;
    logic [13:0] r_r1;
    logic [36:0] r_qd;
    logic [31:0] r_y;
    logic [17:0] r_q2;
    logic        r_moving;
    logic [31:0] r_trip;
    logic [24:0] r_v0;
    logic [24:0] r_v1;
    logic [33:0] r_mag;
    logic        r_neg;
    logic [33:0] r_accq;
    t_div_sel    r_div_sel;

    logic      r_out_valid;
    t_out_item r_out_data;

    logic [31:0]           gap;
    logic [31:0]           span_a;
    logic [31:0]           span_b;
    logic [25:0]           vdiff;
    logic [25:0]           vabs;
    logic [31:0]           recip_arg;
    logic [64:0]           recip_prod;
    logic [31:0]           q1_den;
    logic [37:0]           trip_sum;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [23:0]           speed_val;
    logic [31:0]           accel_val;
    logic                  out_free;

    // differences and operand selection
    always_comb begin
        gap    = i_in_data.now_ms - r_newest;
        span_a = r_newest - r_prev;
        span_b = r_now - r_newest;
        vdiff  = {1'b0, r_v0} - {1'b0, r_v1};
        vabs   = vdiff[25] ? (26'd0 - vdiff) : vdiff;
        case (i_cmd.div_sel)
            DIV_V0: begin
                div_dividend = {r_k, 8'd0, 25'd0};
                div_divisor  = r_d0;
                div_steps    = STEPS_VEL;
            end
            DIV_V1: begin
                div_dividend = {r_k, 8'd0, 25'd0};
                div_divisor  = r_d1;
                div_steps    = STEPS_VEL;
            end
            DIV_ACC: begin
                div_dividend = {r_mag, 16'd0};
                div_divisor  = r_d0;
                div_steps    = STEPS_ACC;
            end
            default: begin
                div_dividend = {r_k, 8'd0, 25'd0};
                div_divisor  = r_d0;
                div_steps    = STEPS_VEL;
            end
        endcase
    end

    // trip arithmetic: count = q1*den + r1, trip = q1*dk + (r1*dk)/den
    always_comb begin
        recip_arg  = i_cmd.tq2 ? r_y : r_count;
        recip_prod = 65'(recip_arg) * 65'(TRIP_RECIP);
        q1_den     = 32'(r_q1) * 32'(TRIP_DEN);
        trip_sum   = 38'(r_qd) + 38'(r_q2);
    end

    // shared iterative divider
    wso_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W),
        .STEP_W     (STEP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // wheel diameter, pulse history, count and initial distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam   <= DIAM_RESET;
            r_newest <= '0;
            r_prev   <= '0;
            r_older  <= '0;
            r_count  <= '0;
            r_init   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_diam <= i_cfg_wdata;
            end
            if (i_cmd.take) begin
                if (i_in_data.op == OP_PULSE && gap >= DEBOUNCE_W) begin
                    r_older  <= r_prev;
                    r_prev   <= r_newest;
                    r_newest <= i_in_data.now_ms;
                    r_count  <= r_count + 32'd1;
                end else if (i_in_data.op == OP_TRIP) begin
                    r_count <= '0;
                    r_init  <= i_in_data.initial_distance_m;
                end
            end
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_now <= i_in_data.now_ms;
        end
        if (i_cmd.prep) begin
            r_d0 <= (span_a > span_b) ? span_a : span_b;
            r_d1 <= r_prev - r_older;
            r_k  <= 17'(r_diam) * 17'(SPEED_FACTOR);
            r_dk <= 18'(r_diam) * 18'(TRIP_NUM);
        end
        if (i_cmd.mul) begin
            r_q1     <= recip_prod[TRIP_SHIFT+18:TRIP_SHIFT];
            r_moving <= {15'd0, r_k} > r_d0;
        end
        if (i_cmd.tsplit) begin
            r_r1 <= 14'(r_count - q1_den);
            r_qd <= 37'(r_q1) * 37'(r_dk);
        end
        if (i_cmd.trem) begin
            r_y <= 32'(r_r1) * 32'(r_dk);
        end
        if (i_cmd.tq2) begin
            r_q2 <= recip_prod[TRIP_SHIFT+17:TRIP_SHIFT];
        end
        if (i_cmd.tsum) begin
            r_trip <= (|trip_sum[37:32]) ? 32'hFFFF_FFFF : trip_sum[31:0];
        end
        if (i_cmd.amul) begin
            r_neg <= vdiff[25];
            r_mag <= 34'(vabs) * 34'(ACCEL_FACTOR);
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (div_done) begin
            case (r_div_sel)
                DIV_V0:  r_v0   <= div_quo[24:0];
                DIV_V1:  r_v1   <= div_quo[24:0];
                DIV_ACC: r_accq <= div_quo[33:0];
                default: ;
            endcase
        end
    end

    // result saturation
    always_comb begin
        speed_val = '0;
        accel_val = '0;
        if (r_moving) begin
            speed_val = r_v0[24] ? 24'hFF_FFFF : r_v0[23:0];
            if (r_mag != '0) begin
                if (r_neg) begin
                    accel_val = (r_accq >= 34'h0_8000_0000) ? 32'h8000_0000
                                                             : (32'd0 - r_accq[31:0]);
                end else begin
                    accel_val = (r_accq > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_accq[31:0];
                end
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.speed_kmh_q8 <= speed_val;
            r_out_data.accel_q8     <= accel_val;
            r_out_data.trip_m       <= r_trip;
            r_out_data.total_m      <= r_init + r_trip;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.op       = i_in_data.op;
        o_sts.moving   = r_moving;
        o_sts.mag_zero = (r_mag == '0);
        o_sts.div_done = div_done;
        o_sts.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/wheel_speed_odometer.sv
// pulse and trip reset leave the block idle, so the next item is taken in the following cycle
// query: at rest the result skips the divider, when both speeds agree it skips the
// acceleration divide; the input is free again in the cycle after the result is loaded
// trip uses reciprocal multiplies, speeds and acceleration the shared
// divider at one quotient bit per cycle (25+25+34 bits); a stalled result adds its wait
// reset (synchronous, active low) clears pulse history, count and distance, diameter to 24
module wheel_speed_odometer #(
    parameter int unsigned DEBOUNCE_MS = wso_pkg::DEBOUNCE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wso_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wso_pkg::t_out_item o_out_data
);
    import wso_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    wso_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // state, arithmetic and output register
    wso_dpath #(
        .DEBOUNCE_MS (DEBOUNCE_MS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/wso_checker.sv
`include "wheel_speed_odometer_macros.svh"

module wso_sva_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input wso_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wso_pkg::t_out_item o_out_data
);
    import wso_pkg::*;

    // a query transfer makes the block busy
    `WSO_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.op == OP_QUERY, o_in_stall, "query transfer did not stall the input")

    // pulses and trip resets produce no result
    `WSO_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.op != OP_QUERY && !o_out_valid, !o_out_valid, "result without a query")

    // a new result appears only at the end of a query
    `WSO_ASSERT_SAME(a_result_from_query, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result while idle")

    // standing still means no acceleration
    `WSO_ASSERT_SAME(a_still_no_accel, i_clk, i_rst_n, o_out_valid && o_out_data.speed_kmh_q8 == 24'd0, o_out_data.accel_q8 == 32'sd0, "acceleration at zero speed")

    // a stalled result holds
    `WSO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind wheel_speed_odometer wso_sva_checker u_wso_checker (.*);
